// ===== rtl/rscs_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants for the rotation-synced column scanner.
// No dependencies; used by the channel interfaces and the top level.
package rscs_pkg;

    typedef logic [1:0]  t_opcode;
    typedef logic [7:0]  t_column;
    typedef logic [2:0]  t_row;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_period;
    typedef logic [31:0] t_us_count;

    localparam t_opcode OP_TICK  = 2'd0;
    localparam t_opcode OP_INDEX = 2'd1;
    localparam t_opcode OP_WRCOL = 2'd2;
    localparam t_opcode OP_WRPIX = 2'd3;

    localparam t_byte   MHZ_RESET    = 8'd72;
    localparam t_period RELOAD_RESET = 16'hFFFF;

    // Control carried from the accept stage to the frame store stage
    typedef struct packed {
        t_opcode op;
        t_column addr;       // frame store entry read at accept
        t_row    row;
        t_byte   value;
        logic    wr_ok;      // in-range column or pixel write
        logic    drive;      // load LEDs from the entry read
        t_column col_shown;
        t_period period;
    } t_stage;

    typedef struct packed {
        t_byte   led_bits;
        logic    led_update;
        t_column column_shown;
        t_period column_period_us;
    } t_result;

endpackage

// ===== rtl/rscs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, results, configuration writes.
// Depends on rscs_pkg.
interface rscs_item_if;
    logic               valid;
    logic               ready;
    rscs_pkg::t_opcode  opcode;
    rscs_pkg::t_column  column;
    rscs_pkg::t_row     row;
    rscs_pkg::t_byte    value;

    modport source (output valid, opcode, column, row, value, input ready);
    modport sink   (input valid, opcode, column, row, value, output ready);
endinterface

interface rscs_res_if;
    logic               valid;
    logic               ready;
    rscs_pkg::t_byte    led_bits;
    logic               led_update;
    rscs_pkg::t_column  column_shown;
    rscs_pkg::t_period  column_period_us;

    modport source (output valid, led_bits, led_update, column_shown, column_period_us,
                    input ready);
    modport sink   (input valid, led_bits, led_update, column_shown, column_period_us,
                    output ready);
endinterface

interface rscs_cfg_if;
    logic               valid;
    logic               ready;
    rscs_pkg::t_byte    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/rotation_synced_column_scanner.sv =====
`timescale 1ns / 1ps
// Rotation-synced LED column scanner: timers, column sequencing, frame store.
// Depends on rscs_pkg and the channel interfaces in rscs_if.sv.
//
//  port      dir  fields                                          role
//  i_item    in   opcode, column, row, value                      tick/index/write items
//  o_res     out  led_bits, led_update, column_shown, period_us   one result per item
//  i_cfg     in   data                                            sys_clock_mhz write
//
// One item per cycle while results are taken; each result passes the stage register and
// then the result register. Timers update at the transfer edge; the frame store
// (synchronous RAM, one read and one write port) is read at that edge and written as the
// stage advances, with a bypass. A stalled result holds the second stage; input ready drops
// once both are full. Synchronous active-low reset; the frame store reads as zero until written.
module rotation_synced_column_scanner #(
    parameter int COLUMNS = 128,
    parameter int LEDS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rscs_item_if.sink   i_item,
    rscs_res_if.source  o_res,
    rscs_cfg_if.sink    i_cfg
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [7:0] LED_MASK = 8'((1 << LEDS) - 1);
    localparam logic [7:0] NCOL     = 8'(COLUMNS);
    localparam logic [AW-1:0] REM_TOP = AW'(COLUMNS - 1);

    // ---------------- configuration ----------------
    logic [7:0] r_mhz;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mhz <= rscs_pkg::MHZ_RESET;
        end else if (i_cfg.valid) begin
            r_mhz <= i_cfg.data;
        end
    end

    // ---------------- pipeline control ----------------
    logic              r_s1_vld;
    rscs_pkg::t_stage  r_s1;
    logic              r_out_vld;
    rscs_pkg::t_result r_out;
    logic              s1_go;
    logic              in_xfer;

    assign s1_go      = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_item.ready = !r_s1_vld || s1_go;
    assign in_xfer    = i_item.valid && i_item.ready;

    // ---------------- timers (accept stage) ----------------
    logic [7:0]    r_pre;
    logic [31:0]   r_elapsed;
    logic [15:0]   r_quot;      // elapsed / COLUMNS, low 16 bits
    logic [AW-1:0] r_rem;       // elapsed % COLUMNS
    logic [15:0]   r_timer;
    logic [15:0]   r_reload;
    logic [7:0]    r_idx;
    logic [15:0]   r_period;

    logic [7:0]    n_pre;
    logic [31:0]   n_elapsed;
    logic [15:0]   n_quot;
    logic [AW-1:0] n_rem;
    logic [15:0]   n_timer;
    logic [15:0]   n_reload;
    logic [7:0]    n_idx;
    logic [15:0]   n_period;
    logic [23:0]   prod;
    logic          drive;
    logic          wr_ok;
    logic [7:0]    rd_col;
    logic [AW-1:0] rd_addr;

    assign prod = 24'(r_quot) * 24'(r_mhz);

    always_comb begin
        n_pre     = r_pre;
        n_elapsed = r_elapsed;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_timer   = r_timer;
        n_reload  = r_reload;
        n_idx     = r_idx;
        n_period  = r_period;
        drive     = 1'b0;
        wr_ok     = 1'b0;
        rd_col    = i_item.column;
        unique case (i_item.opcode)
            rscs_pkg::OP_TICK: begin
                if (r_pre == 8'(r_mhz - 8'd1)) begin
                    n_pre     = '0;
                    n_elapsed = r_elapsed + 32'd1;
                    // quotient tracking restarts when the 32-bit count wraps
                    if (r_elapsed == '1) begin
                        n_quot = '0;
                        n_rem  = '0;
                    end else if (r_rem == REM_TOP) begin
                        n_quot = r_quot + 16'd1;
                        n_rem  = '0;
                    end else begin
                        n_rem  = r_rem + AW'(1);
                    end
                end else begin
                    n_pre = r_pre + 8'd1;
                end
                if (r_timer == r_reload) begin
                    n_timer = '0;
                    if (r_idx < NCOL) n_idx = r_idx + 8'd1;
                    drive = (n_idx < NCOL);
                end else begin
                    n_timer = r_timer + 16'd1;
                end
                rd_col = n_idx;
            end
            rscs_pkg::OP_INDEX: begin
                n_period  = r_quot;
                n_reload  = 16'(prod - 24'd1);
                n_timer   = '0;
                n_pre     = '0;
                n_elapsed = '0;
                n_quot    = '0;
                n_rem     = '0;
                n_idx     = '0;
                drive     = 1'b1;
                rd_col    = '0;
            end
            rscs_pkg::OP_WRCOL: begin
                wr_ok = (i_item.column < NCOL);
            end
            rscs_pkg::OP_WRPIX: begin
                wr_ok = (i_item.column < NCOL) && ({1'b0, i_item.row} < 4'(LEDS))
                        && (i_item.value == 8'd0 || i_item.value == 8'd1);
            end
            default: ;
        endcase
        // out-of-range columns never reach the array index
        rd_addr = (rd_col < NCOL) ? rd_col[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre     <= '0;
            r_elapsed <= '0;
            r_quot    <= '0;
            r_rem     <= '0;
            r_timer   <= '0;
            r_reload  <= rscs_pkg::RELOAD_RESET;
            r_idx     <= '0;
            r_period  <= '0;
        end else if (in_xfer) begin
            r_pre     <= n_pre;
            r_elapsed <= n_elapsed;
            r_quot    <= n_quot;
            r_rem     <= n_rem;
            r_timer   <= n_timer;
            r_reload  <= n_reload;
            r_idx     <= n_idx;
            r_period  <= n_period;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.op        <= i_item.opcode;
            r_s1.addr      <= 8'(rd_addr);
            r_s1.row       <= i_item.row;
            r_s1.value     <= i_item.value;
            r_s1.wr_ok     <= wr_ok;
            r_s1.drive     <= drive;
            r_s1.col_shown <= n_idx;
            r_s1.period    <= n_period;
        end
    end

    // ---------------- frame store ----------------
    logic [7:0]    r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_wvld;     // entry written since reset
    logic [7:0]    r_rd_data;
    logic          r_rd_wvld;
    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;
    logic [7:0]    r_fwd_data;

    logic [AW-1:0] s1_addr;
    logic [7:0]    rd_eff;
    logic [7:0]    pix_bit;
    logic [7:0]    wr_data;
    logic [7:0]    n_led;
    logic [7:0]    r_led;

    assign s1_addr = r_s1.addr[AW-1:0];
    assign pix_bit = 8'd1 << r_s1.row;

    always_comb begin
        // latest write to the entry wins over the stale read
        if (r_fwd_vld && r_fwd_addr == s1_addr) begin
            rd_eff = r_fwd_data;
        end else begin
            rd_eff = r_rd_wvld ? r_rd_data : 8'd0;
        end
        case (r_s1.op)
            rscs_pkg::OP_WRPIX: wr_data = (r_s1.value == 8'd1) ? (rd_eff | pix_bit)
                                                               : (rd_eff & ~pix_bit);
            default:            wr_data = r_s1.value;
        endcase
        n_led = r_s1.drive ? (rd_eff & LED_MASK) : r_led;
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.wr_ok) begin
            r_mem[s1_addr] <= wr_data;
        end
        if (in_xfer) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld    <= '0;
            r_rd_wvld <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_led     <= '0;
        end else begin
            if (in_xfer) r_rd_wvld <= r_wvld[rd_addr];
            if (s1_go) begin
                r_led <= n_led;
                if (r_s1.wr_ok) begin
                    r_wvld[s1_addr] <= 1'b1;
                    r_fwd_vld       <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.wr_ok) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= wr_data;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out.led_bits         <= n_led;
            r_out.led_update       <= r_s1.drive;
            r_out.column_shown     <= r_s1.col_shown;
            r_out.column_period_us <= r_s1.period;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.led_bits         = r_out.led_bits;
    assign o_res.led_update       = r_out.led_update;
    assign o_res.column_shown     = r_out.column_shown;
    assign o_res.column_period_us = r_out.column_period_us;

    // ---------------- assertions ----------------
    a_idx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= NCOL)
        else $error("column index past saturation");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= REM_TOP)
        else $error("microsecond remainder out of range");

    a_update_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.led_update) |-> (r_out.column_shown < NCOL))
        else $error("LED update for a column beyond the frame");

    a_index_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_item.opcode == rscs_pkg::OP_INDEX)
        |=> (r_timer == 16'd0 && r_idx == 8'd0 && r_elapsed == 32'd0))
        else $error("index pulse did not restart the counters");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rotation_synced_column_scanner: a queue-fed item driver,
// a result monitor with random back-pressure, and a cycle-free model of the scanner.
// Depends on rscs_pkg, the channel interfaces in rscs_if.sv and the scanner RTL.
module tb;

    localparam int   COLUMNS  = 128;
    localparam int   LEDS     = 8;
    localparam rscs_pkg::t_byte LED_MASK = rscs_pkg::t_byte'((1 << LEDS) - 1);

    typedef struct packed {
        rscs_pkg::t_opcode opcode;
        rscs_pkg::t_column column;
        rscs_pkg::t_row    row;
        rscs_pkg::t_byte   value;
    } t_scan_item;

    logic i_clk;
    logic i_rst_n;

    rscs_item_if item_bus ();
    rscs_res_if  res_bus ();
    rscs_cfg_if  cfg_bus ();

    rotation_synced_column_scanner #(
        .COLUMNS (COLUMNS),
        .LEDS    (LEDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Scanner model state
    rscs_pkg::t_byte     frame_store [0:COLUMNS-1];
    rscs_pkg::t_byte     clock_mhz;
    rscs_pkg::t_byte     us_prescale;
    rscs_pkg::t_us_count rotation_us;
    rscs_pkg::t_period   col_timer;
    rscs_pkg::t_period   col_reload;
    rscs_pkg::t_column   col_index;
    rscs_pkg::t_byte     led_reg;
    rscs_pkg::t_period   period_reg;

    t_scan_item          items_to_send [$];
    rscs_pkg::t_result   led_results_due [$];

    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned items_queued;
    int unsigned send_gap;
    int unsigned recv_stall;
    bit          quiet_run;

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    function automatic void advance_scanner(input rscs_pkg::t_opcode op,
                                            input rscs_pkg::t_column col,
                                            input rscs_pkg::t_row row,
                                            input rscs_pkg::t_byte val);
        rscs_pkg::t_result res;
        rscs_pkg::t_byte   top;
        rscs_pkg::t_period period;
        logic [31:0]       scaled;
        res.led_update = 1'b0;
        case (op)
            rscs_pkg::OP_TICK: begin
                // clock of zero MHz: top wraps to 255, prescale divides by 256
                top = clock_mhz - 8'd1;
                if (us_prescale == top) begin
                    us_prescale = '0;
                    rotation_us = rotation_us + 32'd1;
                end else begin
                    us_prescale = us_prescale + 8'd1;
                end
                if (col_timer == col_reload) begin
                    col_timer = '0;
                    if (col_index < COLUMNS)
                        col_index = col_index + 8'd1;
                    if (col_index < COLUMNS) begin
                        led_reg        = frame_store[col_index] & LED_MASK;
                        res.led_update = 1'b1;
                    end
                end else begin
                    col_timer = col_timer + 16'd1;
                end
            end
            rscs_pkg::OP_INDEX: begin
                period         = rscs_pkg::t_period'(rotation_us / COLUMNS);
                scaled         = 32'(period) * 32'(clock_mhz) - 32'd1;
                period_reg     = period;
                col_reload     = scaled[15:0];
                col_timer      = '0;
                us_prescale    = '0;
                rotation_us    = '0;
                col_index      = '0;
                led_reg        = frame_store[0] & LED_MASK;
                res.led_update = 1'b1;
            end
            rscs_pkg::OP_WRCOL: begin
                if (col < COLUMNS)
                    frame_store[col] = val;
            end
            default: begin
                if (col < COLUMNS && row < LEDS && val <= 8'd1)
                    frame_store[col][row] = val[0];
            end
        endcase
        res.led_bits         = led_reg;
        res.column_shown     = col_index;
        res.column_period_us = period_reg;
        led_results_due.push_back(res);
    endfunction

    // Item driver: valid is held until the transfer, then the next item follows
    always @(posedge i_clk) begin
        t_scan_item next_item;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            send_gap = 0;
        end else if (!(item_bus.valid && !item_bus.ready)) begin
            if (item_bus.valid)
                advance_scanner(item_bus.opcode, item_bus.column, item_bus.row,
                                item_bus.value);
            if (send_gap != 0 && !quiet_run) begin
                send_gap--;
                item_bus.valid <= 1'b0;
            end else if (items_to_send.size() != 0) begin
                next_item = items_to_send.pop_front();
                item_bus.valid  <= 1'b1;
                item_bus.opcode <= next_item.opcode;
                item_bus.column <= next_item.column;
                item_bus.row    <= next_item.row;
                item_bus.value  <= next_item.value;
                if (!quiet_run && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 7);
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls
    always @(posedge i_clk) begin
        rscs_pkg::t_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b1;
            recv_stall = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (led_results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = led_results_due.pop_front();
                    if (res_bus.led_bits !== want.led_bits)
                        report_mismatch($sformatf("result %0d led_bits 0x%0h, expected 0x%0h",
                                        results_seen, res_bus.led_bits, want.led_bits));
                    if (res_bus.led_update !== want.led_update)
                        report_mismatch($sformatf("result %0d led_update %0b, expected %0b",
                                        results_seen, res_bus.led_update, want.led_update));
                    if (res_bus.column_shown !== want.column_shown)
                        report_mismatch($sformatf("result %0d column_shown %0d, expected %0d",
                                        results_seen, res_bus.column_shown, want.column_shown));
                    if (res_bus.column_period_us !== want.column_period_us)
                        report_mismatch($sformatf("result %0d period %0d, expected %0d",
                                        results_seen, res_bus.column_period_us,
                                        want.column_period_us));
                end
                results_seen++;
            end
            if (recv_stall != 0 && !quiet_run) begin
                recv_stall--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (!quiet_run && $urandom_range(0, 9) == 0)
                    recv_stall = $urandom_range(1, 7);
            end
        end
    end

    task automatic queue_item(input rscs_pkg::t_opcode op, input rscs_pkg::t_column col,
                              input rscs_pkg::t_row row, input rscs_pkg::t_byte val);
        items_to_send.push_back('{op, col, row, val});
        items_queued++;
    endtask

    // Ticks carry random junk in the fields they ignore
    task automatic queue_tick();
        queue_item(rscs_pkg::OP_TICK, rscs_pkg::t_column'($urandom),
                   rscs_pkg::t_row'($urandom), rscs_pkg::t_byte'($urandom));
    endtask

    task automatic queue_random_write();
        rscs_pkg::t_column col;
        rscs_pkg::t_byte   val;
        col = ($urandom_range(0, 9) == 0) ? rscs_pkg::t_column'($urandom_range(128, 255))
                                          : rscs_pkg::t_column'($urandom_range(0, 127));
        if ($urandom_range(0, 1) == 0) begin
            queue_item(rscs_pkg::OP_WRCOL, col, rscs_pkg::t_row'($urandom),
                       rscs_pkg::t_byte'($urandom));
        end else begin
            val = ($urandom_range(0, 5) == 0) ? rscs_pkg::t_byte'($urandom)
                                              : rscs_pkg::t_byte'($urandom_range(0, 1));
            queue_item(rscs_pkg::OP_WRPIX, col, rscs_pkg::t_row'($urandom), val);
        end
    endtask

    // One rotation: index pulse, then ticks with occasional writes and stray pulses
    task automatic queue_rotation(input int unsigned ticks, input int unsigned write_pct,
                                  input bit stray_index);
        queue_item(rscs_pkg::OP_INDEX, rscs_pkg::t_column'($urandom),
                   rscs_pkg::t_row'($urandom), rscs_pkg::t_byte'($urandom));
        for (int unsigned n = 0; n < ticks; n++) begin
            if ($urandom_range(0, 99) < write_pct)
                queue_random_write();
            if (stray_index && $urandom_range(0, 299) == 0)
                queue_item(rscs_pkg::OP_INDEX, rscs_pkg::t_column'($urandom),
                           rscs_pkg::t_row'($urandom), rscs_pkg::t_byte'($urandom));
            queue_tick();
        end
    endtask

    // checked away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (items_to_send.size() != 0 || item_bus.valid || led_results_due.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_clock_mhz(input rscs_pkg::t_byte mhz);
        cfg_bus.data  <= mhz;
        cfg_bus.valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        clock_mhz = mhz;
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int unsigned random_start;
        int unsigned mhz_pick;
        int unsigned ticks;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.opcode = rscs_pkg::OP_TICK;
        item_bus.column = '0;
        item_bus.row    = '0;
        item_bus.value  = '0;
        res_bus.ready  = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.data   = '0;
        mismatch_count = 0;
        results_seen   = 0;
        items_queued   = 0;
        quiet_run      = 1'b0;
        for (int i = 0; i < COLUMNS; i++)
            frame_store[i] = '0;
        clock_mhz   = rscs_pkg::MHZ_RESET;
        us_prescale = '0;
        rotation_us = '0;
        col_timer   = '0;
        col_reload  = rscs_pkg::RELOAD_RESET;
        col_index   = '0;
        led_reg     = '0;
        period_reg  = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset state, range edges of writes, ignored pixel values
        queue_item(rscs_pkg::OP_TICK,  8'd0,   3'd0, 8'd0);
        queue_item(rscs_pkg::OP_INDEX, 8'd255, 3'd7, 8'd255);
        queue_item(rscs_pkg::OP_WRCOL, 8'd0,   3'd0, 8'hFF);
        queue_item(rscs_pkg::OP_WRCOL, 8'd127, 3'd7, 8'hA5);
        queue_item(rscs_pkg::OP_WRCOL, 8'd128, 3'd0, 8'h11);
        queue_item(rscs_pkg::OP_WRCOL, 8'd255, 3'd0, 8'h22);
        queue_item(rscs_pkg::OP_WRPIX, 8'd0,   3'd0, 8'd0);
        queue_item(rscs_pkg::OP_WRPIX, 8'd0,   3'd7, 8'd0);
        queue_item(rscs_pkg::OP_WRPIX, 8'd1,   3'd7, 8'd1);
        queue_item(rscs_pkg::OP_WRPIX, 8'd1,   3'd0, 8'd1);
        queue_item(rscs_pkg::OP_WRPIX, 8'd1,   3'd3, 8'd2);
        queue_item(rscs_pkg::OP_WRPIX, 8'd1,   3'd4, 8'd255);
        queue_item(rscs_pkg::OP_WRPIX, 8'd200, 3'd2, 8'd1);
        queue_item(rscs_pkg::OP_WRPIX, 8'd127, 3'd0, 8'd0);
        queue_item(rscs_pkg::OP_INDEX, 8'd0,   3'd0, 8'd0);
        // write to the column on show: LEDs hold until the next column
        queue_item(rscs_pkg::OP_WRCOL, 8'd0,   3'd0, 8'h00);
        queue_item(rscs_pkg::OP_TICK,  8'd255, 3'd7, 8'hFF);
        wait_drained();

        // 1 MHz: period of one us gives a column per tick, runs past the last column
        write_clock_mhz(8'd1);
        queue_rotation(128, 0, 1'b0);
        queue_rotation(140, 4, 1'b0);
        queue_item(rscs_pkg::OP_INDEX, 8'd0, 3'd0, 8'd0);
        wait_drained();

        // 255 MHz: a short rotation gives period 0, the reload wraps to all ones
        write_clock_mhz(8'd255);
        queue_rotation(60, 3, 1'b0);
        wait_drained();

        // zero MHz: prescale by 256, reload wraps to all ones
        write_clock_mhz(8'd0);
        queue_rotation(60, 3, 1'b0);
        wait_drained();

        random_start = items_queued;
        while (items_queued - random_start < 250) begin
            mhz_pick = $urandom_range(0, 7);
            if (mhz_pick <= 4)
                write_clock_mhz(rscs_pkg::t_byte'($urandom_range(1, 2)));
            else if (mhz_pick == 5)
                write_clock_mhz(8'd255);
            else
                write_clock_mhz(rscs_pkg::t_byte'($urandom_range(1, 255)));
            repeat (2) begin
                if (clock_mhz <= 2 && clock_mhz != 0)
                    ticks = 128 * clock_mhz + $urandom_range(0, 40);
                else
                    ticks = $urandom_range(10, 150);
                queue_rotation(ticks, 12, 1'b1);
            end
            wait_drained();
        end

        // closing stretch with no idling on either side
        quiet_run = 1'b1;
        write_clock_mhz(8'd1);
        queue_rotation(128 + $urandom_range(0, 10), 10, 1'b0);
        queue_rotation(140, 10, 1'b0);
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (led_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", led_results_due.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(200_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
